[rtl/bsmc_pkg.sv]
// ----------------------------------------------------------------------------
// bsmc_pkg
// shared types and constants for the bone skin matrix concatenation block
// ----------------------------------------------------------------------------
package bsmc_pkg;

    // element format: signed q10.10, 21 bits
    localparam int ELEM_W = 21;
    localparam int ROW_W  = 3 * ELEM_W;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int SUM_W  = PROD_W + 3;
    localparam int FRAC_W = 10;
    localparam int Q_W    = SUM_W - FRAC_W;
    localparam int IDX_W  = 8;
    localparam int CFG_IDX_W = 2;

    // rounding bias, half of one q10.10 step in q20.20
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(512);

    // saturation limits on the rounded value
    localparam logic signed [Q_W-1:0] ELEM_MAX_Q = Q_W'(1048575);
    localparam logic signed [Q_W-1:0] ELEM_MIN_Q = -Q_W'(1048576);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_XFORM_RIGHT = 2'd0,
        CFG_XFORM_UP    = 2'd1,
        CFG_XFORM_AT    = 2'd2,
        CFG_XFORM_POS   = 2'd3
    } cfg_idx_t;

    // matrix rows: element 0 (x) in the low bits, as packed on the ports
    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef elem_t [2:0] row_t;
    typedef row_t [3:0] mat_t;

    // data that rides along with each bone through the pipeline
    typedef struct packed {
        logic [IDX_W-1:0] bone_index;
        logic             last;
        logic             sat;
    } side_t;

endpackage

[rtl/bsmc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bsmc_cfg_regs
// global transform register file, written through the configuration port
// ----------------------------------------------------------------------------
module bsmc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [bsmc_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [bsmc_pkg::ROW_W-1:0]    wr_data,
    output bsmc_pkg::mat_t                xform
);
    import bsmc_pkg::*;

    row_t xform_reg [4];

    // register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                xform_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_XFORM_RIGHT: xform_reg[0] <= row_t'(wr_data);
                CFG_XFORM_UP:    xform_reg[1] <= row_t'(wr_data);
                CFG_XFORM_AT:    xform_reg[2] <= row_t'(wr_data);
                CFG_XFORM_POS:   xform_reg[3] <= row_t'(wr_data);
                default:         ;
            endcase
        end
    end

    // matrix view of the rows
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            xform[i] = xform_reg[i];
        end
    end

endmodule

[rtl/bsmc_affine_stage.sv]
// ----------------------------------------------------------------------------
// bsmc_affine_stage
// three-stage 4x3 affine product: multiply, sum with bias, round and clip
// ----------------------------------------------------------------------------
module bsmc_affine_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  bsmc_pkg::mat_t  left,
    input  bsmc_pkg::mat_t  right,
    input  bsmc_pkg::side_t in_side,
    output logic            out_valid,
    output bsmc_pkg::mat_t  result,
    output bsmc_pkg::side_t out_side
);
    import bsmc_pkg::*;

    // stage 1 registers
    logic                    v1_reg;
    logic signed [PROD_W-1:0] prod_reg [4][3][3];
    logic signed [PROD_W-1:0] prod_next [4][3][3];
    row_t                    pos1_reg;
    side_t                   side1_reg;

    // stage 2 registers
    logic                    v2_reg;
    logic signed [SUM_W-1:0] sum_reg [4][3];
    logic signed [SUM_W-1:0] sum_next [4][3];
    side_t                   side2_reg;

    // stage 3 registers
    logic                    v3_reg;
    mat_t                    res_reg;
    mat_t                    res_next;
    side_t                   side3_reg;
    logic                    sat_next;

    // one multiplier per term
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_next[i][j][k] = left[i][k] * right[k][j];
                end
            end
        end
    end

    // three-term sum, translation term on the position row, rounding bias
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sum_next[i][j] = SUM_W'(prod_reg[i][j][0]) + SUM_W'(prod_reg[i][j][1])
                               + SUM_W'(prod_reg[i][j][2]) + ROUND_BIAS;
                if (i == 3)
                begin
                    sum_next[i][j] = sum_next[i][j]
                                   + (SUM_W'(pos1_reg[j]) <<< FRAC_W);
                end
            end
        end
    end

    // floor shift to q10.10 and clip to the element range
    always_comb
    begin
        logic signed [Q_W-1:0] q;
        sat_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                q = sum_reg[i][j][SUM_W-1:FRAC_W];
                if (q > ELEM_MAX_Q)
                begin
                    res_next[i][j] = ELEM_MAX_Q[ELEM_W-1:0];
                    sat_next = 1'b1;
                end
                else if (q < ELEM_MIN_Q)
                begin
                    res_next[i][j] = ELEM_MIN_Q[ELEM_W-1:0];
                    sat_next = 1'b1;
                end
                else
                begin
                    res_next[i][j] = q[ELEM_W-1:0];
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            pos1_reg  <= right[3];
            side1_reg <= in_side;
            sum_reg   <= sum_next;
            side2_reg <= side1_reg;
            res_reg   <= res_next;
            side3_reg <= '{bone_index: side2_reg.bone_index,
                           last:       side2_reg.last,
                           sat:        side2_reg.sat | sat_next};
        end
    end

    assign out_valid = v3_reg;
    assign result    = res_reg;
    assign out_side  = side3_reg;

endmodule

[rtl/bone_skin_matrix_concat.sv]
// ----------------------------------------------------------------------------
// bone_skin_matrix_concat
// per-bone matrix concatenation: dest = skin * (hierarchy * global transform)
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     in_valid / in_stall   bone_index, hier_*_row, skin_*_row, last_bone
//  output    out_valid / out_stall out_bone_index, dest_*_row, out_last, saturated
//  config    cfg_valid / cfg_ready cfg_index, cfg_data (cfg_ready is always high)
//
//  one bone enters per cycle while the pipeline is not frozen; two
//  three-stage affine units (multiply, sum, round and clip) run back to
//  back, the last register of the second unit being the output register.
//  reset clears the valid bits and the transform registers.
//  an output stall on a valid result freezes the whole pipeline and is
//  passed straight to in_stall, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module bone_skin_matrix_concat (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bsmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsmc_pkg::ROW_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [bsmc_pkg::IDX_W-1:0]     bone_index,
    input  logic [bsmc_pkg::ROW_W-1:0]     hier_right_row,
    input  logic [bsmc_pkg::ROW_W-1:0]     hier_up_row,
    input  logic [bsmc_pkg::ROW_W-1:0]     hier_at_row,
    input  logic [bsmc_pkg::ROW_W-1:0]     hier_pos_row,
    input  logic [bsmc_pkg::ROW_W-1:0]     skin_right_row,
    input  logic [bsmc_pkg::ROW_W-1:0]     skin_up_row,
    input  logic [bsmc_pkg::ROW_W-1:0]     skin_at_row,
    input  logic [bsmc_pkg::ROW_W-1:0]     skin_pos_row,
    input  logic                           last_bone,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bsmc_pkg::IDX_W-1:0]     out_bone_index,
    output logic [bsmc_pkg::ROW_W-1:0]     dest_right_row,
    output logic [bsmc_pkg::ROW_W-1:0]     dest_up_row,
    output logic [bsmc_pkg::ROW_W-1:0]     dest_at_row,
    output logic [bsmc_pkg::ROW_W-1:0]     dest_pos_row,
    output logic                           out_last,
    output logic                           saturated
);
    import bsmc_pkg::*;

    logic  pipe_en;
    mat_t  xform;
    mat_t  hier_mat;
    mat_t  h_mat;
    mat_t  d_mat;
    side_t in_side;
    side_t h_side;
    side_t d_side;
    logic  h_valid;
    logic  skin_valid_reg;
    mat_t  skin_d1_reg;
    mat_t  skin_d2_reg;
    mat_t  skin_d3_reg;

    // pipeline advances unless a finished result is held
    assign pipe_en   = !(out_valid && out_stall);
    assign in_stall  = !pipe_en;
    assign cfg_ready = 1'b1;

    bsmc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .xform    (xform)
    );

    // input unpacking
    assign hier_mat[0] = row_t'(hier_right_row);
    assign hier_mat[1] = row_t'(hier_up_row);
    assign hier_mat[2] = row_t'(hier_at_row);
    assign hier_mat[3] = row_t'(hier_pos_row);
    assign in_side = '{bone_index: bone_index, last: last_bone, sat: 1'b0};

    // skin matrix delayed to meet h at the second unit
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            skin_d1_reg[0] <= row_t'(skin_right_row);
            skin_d1_reg[1] <= row_t'(skin_up_row);
            skin_d1_reg[2] <= row_t'(skin_at_row);
            skin_d1_reg[3] <= row_t'(skin_pos_row);
            skin_d2_reg    <= skin_d1_reg;
            skin_d3_reg    <= skin_d2_reg;
        end
    end

    // marks a bone in the skin delay line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skin_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            skin_valid_reg <= in_valid;
        end
    end

    // h = hierarchy * transform
    bsmc_affine_stage u_hier (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (in_valid && skin_valid_reg | in_valid),
        .left      (hier_mat),
        .right     (xform),
        .in_side   (in_side),
        .out_valid (h_valid),
        .result    (h_mat),
        .out_side  (h_side)
    );

    // dest = skin * h
    bsmc_affine_stage u_dest (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (h_valid),
        .left      (skin_d3_reg),
        .right     (h_mat),
        .in_side   (h_side),
        .out_valid (out_valid),
        .result    (d_mat),
        .out_side  (d_side)
    );

    // output fields
    assign out_bone_index = d_side.bone_index;
    assign dest_right_row = ROW_W'(d_mat[0]);
    assign dest_up_row    = ROW_W'(d_mat[1]);
    assign dest_at_row    = ROW_W'(d_mat[2]);
    assign dest_pos_row   = ROW_W'(d_mat[3]);
    assign out_last       = d_side.last;
    assign saturated      = d_side.sat;

endmodule
